// ----- rtl/smpd_pkg.sv -----
// smpd_pkg: constants and types for the serial mouse packet decoder
// no dependencies; imported by serial_mouse_packet_decoder and its testbench
`default_nettype none

package smpd_pkg;

    // sync byte detection
    localparam logic [7:0] SYNC_MASK  = 8'hF8;
    localparam logic [7:0] SYNC_VALUE = 8'h80;
    localparam logic [2:0] BTN_IDLE   = 3'h7;

    // frame layout: position 0 waits for sync, 1..4 count received bytes
    localparam int unsigned FRAME_LEN = 5;
    localparam int unsigned POS_W     = 3;
    localparam logic [POS_W-1:0] POS_SYNC = '0;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);

    // output item fields
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned BTN_W   = 2;
    localparam int unsigned DX_W    = 9;
    localparam int unsigned DY_W    = 10;
    localparam int unsigned ODATA_W = 24;

    typedef enum logic [KIND_W-1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_MOTION  = 2'd2
    } t_event_kind;

    // pending event flags, drained in order btn1, btn2, btn3, motion
    typedef struct packed {
        logic btn1;
        logic btn2;
        logic btn3;
        logic motion;
    } t_pend;

endpackage

`default_nettype wire

// ----- rtl/serial_mouse_packet_decoder.sv -----
// serial_mouse_packet_decoder: five-byte serial mouse frame to button/motion items
// depends on smpd_pkg
//
//  channel   dir  handshake                      payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata[7:0] = rx_byte
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata = button_number, delta_x,
//                                                 delta_y; tuser = event_kind;
//                                                 tlast = last_event
//
// a byte is taken every cycle unless held off; the fifth byte of a frame loads up
// to four events into a pending set that drains one item per cycle while the
// output is free; each event passes from that set into the output register.
// a fifth byte is held off only while events of the previous frame are pending.
// reset (synchronous, active low) clears framing, sets buttons to all released
// and empties the pending set and the output register.
`default_nettype none

module serial_mouse_packet_decoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [7:0]                    i_s_axis_tdata,  // [7:0] rx_byte
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // [1:0] button_number, [10:2] delta_x, [20:11] delta_y, [23:21] zero
    output logic [smpd_pkg::ODATA_W-1:0]       o_m_axis_tdata,
    output logic [smpd_pkg::KIND_W-1:0]        o_m_axis_tuser,  // [1:0] event_kind
    output logic                               o_m_axis_tlast   // last_event
);

    import smpd_pkg::*;

    // framing state
    logic [POS_W-1:0] r_pos, n_pos;
    logic [2:0]       r_hdr_btn;
    logic [2:0]       r_prior;
    logic [7:0]       r_motion [0:2];

    // pending events of the last completed frame
    t_pend            r_pend, n_pend;
    logic [2:0]       r_ev_btn;
    logic [DX_W-1:0]  r_ev_dx;
    logic [DY_W-1:0]  r_ev_dy;

    // output register
    logic              r_out_valid;
    t_event_kind       r_out_kind;
    logic [BTN_W-1:0]  r_out_btn;
    logic [DX_W-1:0]   r_out_dx;
    logic [DY_W-1:0]   r_out_dy;
    logic              r_out_last;

    logic             in_fire;
    logic             frame_end;
    logic             is_sync;
    logic [2:0]       btn_chg;
    logic [DX_W-1:0]  dx_sum;
    logic [DY_W-1:0]  dy_sum;
    logic [DY_W-1:0]  dy_neg;
    logic             out_free;
    logic             drain;
    t_event_kind      sel_kind;
    logic [BTN_W-1:0] sel_btn;
    logic             sel_motion;
    t_pend            pend_after;

    // input handshake: only a frame end must wait for the pending set
    assign frame_end       = (r_pos == POS_LAST);
    assign o_s_axis_tready = !(frame_end && (r_pend != '0));
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign is_sync         = ((i_s_axis_tdata & SYNC_MASK) == SYNC_VALUE);

    // frame-end arithmetic, bytes taken as signed
    assign btn_chg = r_hdr_btn ^ r_prior;
    assign dx_sum  = {r_motion[0][7], r_motion[0]} + {r_motion[2][7], r_motion[2]};
    assign dy_sum  = {{2{r_motion[1][7]}}, r_motion[1]}
                   + {{2{i_s_axis_tdata[7]}}, i_s_axis_tdata};
    assign dy_neg  = DY_W'(0) - dy_sum;

    // next frame position
    always_comb begin
        n_pos = r_pos;
        if (r_pos == POS_SYNC) begin
            if (is_sync) begin
                n_pos = POS_SYNC + POS_W'(1);
            end
        end else if (frame_end) begin
            n_pos = POS_SYNC;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    // pick the next pending event in button then motion order
    always_comb begin
        sel_kind   = KIND_MOTION;
        sel_btn    = '0;
        sel_motion = 1'b0;
        pend_after = r_pend;
        if (r_pend.btn1) begin
            sel_kind        = r_ev_btn[2] ? KIND_RELEASE : KIND_PRESS;
            sel_btn         = BTN_W'(1);
            pend_after.btn1 = 1'b0;
        end else if (r_pend.btn2) begin
            sel_kind        = r_ev_btn[1] ? KIND_RELEASE : KIND_PRESS;
            sel_btn         = BTN_W'(2);
            pend_after.btn2 = 1'b0;
        end else if (r_pend.btn3) begin
            sel_kind        = r_ev_btn[0] ? KIND_RELEASE : KIND_PRESS;
            sel_btn         = BTN_W'(3);
            pend_after.btn3 = 1'b0;
        end else begin
            sel_motion        = 1'b1;
            pend_after.motion = 1'b0;
        end
    end

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign drain    = out_free && (r_pend != '0);

    // pending set update: drain one, or load a new frame (only when empty)
    always_comb begin
        n_pend = r_pend;
        if (drain) begin
            n_pend = pend_after;
        end
        if (in_fire && frame_end) begin
            n_pend.btn1   = btn_chg[2];
            n_pend.btn2   = btn_chg[1];
            n_pend.btn3   = btn_chg[0];
            n_pend.motion = (dx_sum != '0) || (dy_sum != '0);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_SYNC;
            r_hdr_btn   <= '0;
            r_prior     <= BTN_IDLE;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_pos <= n_pos;
                if (r_pos == POS_SYNC && is_sync) begin
                    r_hdr_btn <= i_s_axis_tdata[2:0];
                end
                if (frame_end) begin
                    r_prior <= r_hdr_btn;
                end
            end
            r_pend <= n_pend;
            if (drain) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire && r_pos != POS_SYNC && !frame_end) begin
            r_motion[2'(r_pos - POS_W'(1))] <= i_s_axis_tdata;
        end
        if (in_fire && frame_end) begin
            r_ev_btn <= r_hdr_btn;
            r_ev_dx  <= dx_sum;
            r_ev_dy  <= dy_neg;
        end
        if (drain) begin
            r_out_kind <= sel_kind;
            r_out_btn  <= sel_btn;
            r_out_dx   <= sel_motion ? r_ev_dx : '0;
            r_out_dy   <= sel_motion ? r_ev_dy : '0;
            r_out_last <= (pend_after == '0);
        end
    end

    // output ports
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_dy, r_out_dx, r_out_btn};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    // frame position stays within the frame
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("frame position out of range");

    // input held off only while a previous frame still has events
    a_ready_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_pend != '0))
        else $error("input stalled with nothing pending");

    // while events are pending, the output register always holds an item next cycle
    a_pend_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend != '0) |=> r_out_valid)
        else $error("pending event not presented");

    // button state follows the header at frame end
    a_prior_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && frame_end) |=> (r_prior == $past(r_hdr_btn)))
        else $error("prior buttons not updated");

    // motion items carry no button number
    a_motion_btn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_MOTION) |-> (r_out_btn == '0))
        else $error("motion item with button number");

endmodule

`default_nettype wire

// ----- sim/serial_mouse_packet_decoder_test.sv -----
// serial_mouse_packet_decoder_test: self-checking testbench for the serial mouse decoder
// depends on smpd_pkg and serial_mouse_packet_decoder; drives bytes, checks every event item
`default_nettype none

module serial_mouse_packet_decoder_test;
    import smpd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;

    // one decoded event as seen on the output stream
    typedef struct packed {
        t_event_kind       kind;
        logic [1:0]        button;
        logic signed [8:0] dx;
        logic signed [9:0] dy;
        logic              last;
    } t_mouse_event;

    localparam t_mouse_event NO_EVENT = '0;

    // directed row: typed rows carry their result in ev, ev.last marks that one is due
    typedef struct packed {
        logic [7:0]   rx;
        logic         typed;
        t_mouse_event ev;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_axis_tvalid;
    logic               o_s_axis_tready;
    logic [7:0]         i_s_axis_tdata;   // [7:0] rx_byte
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready;
    // [1:0] button_number, [10:2] delta_x, [20:11] delta_y, [23:21] zero
    logic [ODATA_W-1:0] o_m_axis_tdata;
    logic [KIND_W-1:0]  o_m_axis_tuser;   // [1:0] event_kind
    logic               o_m_axis_tlast;   // last_event

    serial_mouse_packet_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // decoder state mirrored by the testbench
    logic [POS_W-1:0] frame_pos;
    logic [2:0]       hdr_buttons;
    logic [7:0]       motion_bytes [4];
    logic [2:0]       prior_buttons;

    t_mouse_event expected_events [$];
    int           failures;
    int           events_predicted;
    int           events_seen;
    int           cycle_count;
    int           send_calm;
    int           recv_calm;

    // directed frames: noise, motion extremes, all pressed, partial release, quiet frame
    t_stim_row directed_rows [26] = '{
        // noise while waiting for sync is dropped
        '{8'hFF, 1'b1, NO_EVENT},
        // all released, largest positive motion, sync-like bytes mid-frame
        '{8'h87, 1'b1, NO_EVENT},
        '{8'h7F, 1'b1, NO_EVENT},
        '{8'h80, 1'b1, NO_EVENT},
        '{8'h7F, 1'b1, NO_EVENT},
        '{8'h80, 1'b1, '{KIND_MOTION, 2'd0, 9'sd254, 10'sd256, 1'b1}},
        // all three pressed then small motion: four items
        '{8'h80, 1'b0, NO_EVENT},
        '{8'h01, 1'b0, NO_EVENT},
        '{8'hFF, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, NO_EVENT},
        // buttons 1 and 3 released, no motion
        '{8'h85, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, NO_EVENT},
        '{8'h00, 1'b0, NO_EVENT},
        // no change and no motion: nothing comes out
        '{8'h85, 1'b1, NO_EVENT},
        '{8'h00, 1'b1, NO_EVENT},
        '{8'h00, 1'b1, NO_EVENT},
        '{8'h00, 1'b1, NO_EVENT},
        '{8'h00, 1'b1, NO_EVENT},
        // largest negative motion, dx is -256
        '{8'h85, 1'b1, NO_EVENT},
        '{8'h80, 1'b1, NO_EVENT},
        '{8'h7F, 1'b1, NO_EVENT},
        '{8'h80, 1'b1, NO_EVENT},
        '{8'h7F, 1'b1, '{KIND_MOTION, 2'd0, 9'h100, -10'sd254, 1'b1}}
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // decode one accepted byte; returns the number of events it causes
    function automatic int decode_mouse_byte(input logic [7:0] b, input bit keep);
        t_mouse_event      evs [4];
        int                n;
        int                k;
        int                dx_sum;
        int                dy_sum;
        logic [2:0]        mask;
        logic signed [7:0] x1, y1, x2, y2;
        n = 0;
        if (frame_pos == POS_SYNC) begin
            if ((b & SYNC_MASK) == SYNC_VALUE) begin
                hdr_buttons = b[2:0];
                frame_pos = POS_W'(1);
            end
            return 0;
        end
        motion_bytes[2'(frame_pos - POS_W'(1))] = b;
        if (frame_pos != POS_LAST) begin
            frame_pos = frame_pos + POS_W'(1);
            return 0;
        end
        frame_pos = POS_SYNC;
        // button changes in order 1, 2, 3; bit set means released
        for (k = 0; k < 3; k++) begin
            mask = 3'b100 >> k;
            if ((hdr_buttons & mask) != (prior_buttons & mask)) begin
                evs[n] = NO_EVENT;
                evs[n].kind = ((hdr_buttons & mask) != 3'b000) ? KIND_RELEASE : KIND_PRESS;
                evs[n].button = 2'(k + 1);
                n++;
            end
        end
        prior_buttons = hdr_buttons;
        // motion from signed byte sums, y inverted
        x1 = motion_bytes[0];
        y1 = motion_bytes[1];
        x2 = motion_bytes[2];
        y2 = motion_bytes[3];
        dx_sum = int'(x1) + int'(x2);
        dy_sum = -(int'(y1) + int'(y2));
        if (dx_sum != 0 || dy_sum != 0) begin
            evs[n] = NO_EVENT;
            evs[n].kind = KIND_MOTION;
            evs[n].dx = 9'(dx_sum);
            evs[n].dy = 10'(dy_sum);
            n++;
        end
        if (n > 0)
            evs[n - 1].last = 1'b1;
        if (keep) begin
            for (k = 0; k < n; k++)
                expected_events.push_back(evs[k]);
        end
        return n;
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endfunction

    // short gaps mostly, a few long ones, and calm stretches with none
    function automatic int pick_send_gap();
        int r;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            send_calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    function automatic logic [7:0] pick_motion_byte();
        case ($urandom_range(0, 9))
            0: return 8'h80;
            1: return 8'h7F;
            2: return 8'h00;
            3: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // offer one byte, wait for its handshake, then predict
    task automatic send_byte(input logic [7:0] b, input logic typed, input t_mouse_event ev);
        int gap;
        int n;
        gap = pick_send_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        n = decode_mouse_byte(b, !typed);
        if (typed && ev.last) begin
            expected_events.push_back(ev);
            n = 1;
        end else if (typed) begin
            n = 0;
        end
        events_predicted += n;
    endtask

    // compare one output item with the oldest expectation
    task automatic check_event();
        t_mouse_event      want;
        logic [1:0]        got_btn;
        logic signed [8:0] got_dx;
        logic signed [9:0] got_dy;
        logic [2:0]        got_pad;
        got_btn = o_m_axis_tdata[1:0];
        got_dx  = o_m_axis_tdata[10:2];
        got_dy  = o_m_axis_tdata[20:11];
        got_pad = o_m_axis_tdata[23:21];
        events_seen++;
        if (expected_events.size() == 0) begin
            note_failure($sformatf(
                "unexpected item: kind=%0d button=%0d dx=%0d dy=%0d last=%0b",
                o_m_axis_tuser, got_btn, got_dx, got_dy, o_m_axis_tlast));
            return;
        end
        want = expected_events.pop_front();
        if (o_m_axis_tuser !== want.kind || got_btn !== want.button || got_dx !== want.dx
                || got_dy !== want.dy || o_m_axis_tlast !== want.last || got_pad !== 3'b000)
            note_failure($sformatf(
                "item %0d mismatch: exp kind=%0d button=%0d dx=%0d dy=%0d last=%0b, %s",
                events_seen, want.kind, want.button, want.dx, want.dy, want.last,
                $sformatf("got kind=%0d button=%0d dx=%0d dy=%0d last=%0b pad=%0h",
                    o_m_axis_tuser, got_btn, got_dx, got_dy, o_m_axis_tlast, got_pad)));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            check_event();
    end

    // receiver: random stalls, calm stretches, and two long hold-offs
    initial begin
        int hold_left;
        int stall_left;
        int holds_done;
        int r;
        hold_left = 0;
        stall_left = 0;
        holds_done = 0;
        recv_calm = 0;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_done < 2
                    && events_seen >= (holds_done == 0 ? 12 : 40)) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (recv_calm > 0) begin
                recv_calm--;
                i_m_axis_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    recv_calm = $urandom_range(20, 60);
                    i_m_axis_tready <= 1'b1;
                end else if (r < 75) begin
                    i_m_axis_tready <= 1'b1;
                end else begin
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                    i_m_axis_tready <= 1'b0;
                end
            end
        end
    end

    // reset, directed table, random frames, drain and verdict
    initial begin
        int         row;
        int         k;
        int         frame_items;
        int         wait_cycles;
        logic       quiet_frame;
        i_rst_n          = 1'b0;
        i_s_axis_tvalid  = 1'b0;
        i_s_axis_tdata   = 8'h00;
        failures         = 0;
        events_predicted = 0;
        events_seen      = 0;
        send_calm        = 0;
        frame_pos        = POS_SYNC;
        hdr_buttons      = 3'b000;
        prior_buttons    = BTN_IDLE;
        for (k = 0; k < 4; k++)
            motion_bytes[k] = 8'h00;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < 26; row++)
            send_byte(directed_rows[row].rx, directed_rows[row].typed, directed_rows[row].ev);

        // mostly well-formed frames with random content, some noise bytes
        frame_items = 0;
        while (frame_items < 200 || events_predicted < 48) begin
            if ($urandom_range(0, 9) == 0) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0, NO_EVENT);
            end else begin
                quiet_frame = ($urandom_range(0, 4) == 0);
                send_byte(SYNC_VALUE | 8'($urandom_range(0, 7)), 1'b0, NO_EVENT);
                for (k = 0; k < 4; k++)
                    send_byte(quiet_frame ? 8'h00 : pick_motion_byte(), 1'b0, NO_EVENT);
                frame_items += 5;
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;

        // drain, then keep watching for stray items before the verdict
        wait_cycles = 0;
        while (expected_events.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(posedge i_clk);
        if (expected_events.size() != 0)
            note_failure($sformatf("%0d expected items never arrived", expected_events.size()));

        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/smpd_pkg.sv
rtl/serial_mouse_packet_decoder.sv
sim/serial_mouse_packet_decoder_test.sv
